### hdl/obsp_pkg.sv
// ----------------------------------------------------------------------------
// Order-book sweep pricer package
// Shared types, widths and codes for the sweep pricer and its channels.
// ----------------------------------------------------------------------------
package obsp_pkg;

    localparam int PRICE_W    = 31;
    localparam int SIZE_W     = 28;
    localparam int MID_W      = 32;
    localparam int DEPTH_W    = 33;
    localparam int NOTIONAL_W = 59;
    localparam int FRAC_W     = 16;
    localparam int MODE_W     = 2;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;

    localparam int MAX_LEVELS_DEF = 20;

    typedef enum logic [MODE_W-1:0] {
        MODE_PARTIAL = 2'd0,
        MODE_FULL    = 2'd1,
        MODE_DEPTH   = 2'd2,
        MODE_SPARE   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE       = 2'd0,
        REG_SIDE       = 2'd1,
        REG_ORDER_QTY  = 2'd2,
        REG_DEPTH_FRAC = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [PRICE_W-1:0] bid_price;
        logic [SIZE_W-1:0]  bid_size;
        logic [PRICE_W-1:0] ask_price;
        logic [SIZE_W-1:0]  ask_size;
        logic               last_level;
    } level_t;

    typedef struct packed {
        logic [PRICE_W-1:0] avg_price;
        logic [SIZE_W-1:0]  filled_qty;
        logic [DEPTH_W-1:0] depth_total;
    } result_t;

endpackage

### hdl/obsp_level_if.sv
// ----------------------------------------------------------------------------
// Order-book level channel
// Valid/ready channel that carries one book level per beat.
// ----------------------------------------------------------------------------
interface obsp_level_if;

    logic            valid;
    logic            ready;
    obsp_pkg::level_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

### hdl/obsp_result_if.sv
// ----------------------------------------------------------------------------
// Sweep result channel
// Valid/ready channel that carries one snapshot result per beat.
// ----------------------------------------------------------------------------
interface obsp_result_if;

    logic             valid;
    logic             ready;
    obsp_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

### hdl/order_book_sweep_price.sv
// ----------------------------------------------------------------------------
// Order-book sweep pricer
// Sweeps one side of a streamed book snapshot and reports the average fill
// price, the filled quantity and, in depth mode, the depth near the mid price.
// ----------------------------------------------------------------------------
// Each level beat passes through the accept state, S_SWEEP_MUL, S_SWEEP_ACC
// and S_DEPTH; a single shared 32x32 multiplier forms the fill notional and
// then the depth limit. Levels past MAX_LEVELS are accepted and skipped.
// After the beat that ends a snapshot, the result passes through a multiply
// for the remainder, a setup step, 59 steps of a one-bit-per-cycle restoring
// divider (skipped for a zero divisor) and a load of the output register.
// Depth mode skips the setup and the divider. A finished result sits in an
// output register, and the next snapshot is accepted while it waits.
module order_book_sweep_price #(
    parameter int MAX_LEVELS = obsp_pkg::MAX_LEVELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [obsp_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [obsp_pkg::CFG_DATA_W-1:0]   cfg_data,
    obsp_level_if.sink                        book,
    obsp_result_if.source                     result
);

    localparam int LVL_W   = $clog2(MAX_LEVELS + 1);
    localparam int DIV_N   = obsp_pkg::NOTIONAL_W;
    localparam int CNT_W   = $clog2(DIV_N);
    localparam int PRICE_W = obsp_pkg::PRICE_W;
    localparam int SIZE_W  = obsp_pkg::SIZE_W;
    localparam int MUL_W   = obsp_pkg::MUL_W;
    localparam int PROD_W  = obsp_pkg::PROD_W;
    localparam int DEPTH_W = obsp_pkg::DEPTH_W;
    localparam int FRAC_W  = obsp_pkg::FRAC_W;
    localparam int MID_W   = obsp_pkg::MID_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP_MUL,
        S_SWEEP_ACC,
        S_DEPTH,
        S_FINAL,
        S_PREP,
        S_DIV,
        S_OUT
    } state_t;

    state_t                          state_reg;
    obsp_pkg::mode_t                 mode_reg;
    logic                            side_reg;
    logic [SIZE_W-1:0]               order_qty_reg;
    logic [FRAC_W-1:0]               depth_frac_reg;

    logic [PRICE_W-1:0]              px_reg;
    logic [SIZE_W-1:0]               sz_reg;
    logic                            last_reg;
    logic [LVL_W-1:0]                level_index_reg;
    logic [SIZE_W-1:0]               remaining_reg;
    logic [obsp_pkg::NOTIONAL_W-1:0] notional_reg;
    logic [SIZE_W-1:0]               filled_reg;
    logic [PRICE_W-1:0]              last_touched_reg;
    logic [PRICE_W-1:0]              best_price_reg;
    logic [MID_W-1:0]                mid_twice_reg;
    logic [DEPTH_W-1:0]              depth_sum_reg;
    logic                            walk_stopped_reg;
    logic                            depth_stopped_reg;
    logic [PROD_W-1:0]               product_reg;
    logic [DIV_N-1:0]                quo_reg;
    logic [SIZE_W-1:0]               div_rem_reg;
    logic [SIZE_W-1:0]               divisor_reg;
    logic [CNT_W-1:0]                div_cnt_reg;
    logic                            out_valid_reg;
    obsp_pkg::result_t               out_data_reg;

    logic                            accept;
    logic                            level_active;
    logic [PRICE_W-1:0]              in_px;
    logic [SIZE_W-1:0]               in_sz;
    logic [SIZE_W-1:0]               take;
    logic                            sweep_go;
    logic [FRAC_W:0]                 depth_factor;
    logic [PRICE_W-1:0]              fill_price;
    logic [MUL_W-1:0]                mul_a;
    logic [MUL_W-1:0]                mul_b;
    logic [PROD_W-1:0]               depth_lhs;
    logic                            depth_beyond;
    logic [DIV_N-1:0]                dividend;
    logic [SIZE_W-1:0]               divisor;
    logic [SIZE_W:0]                 rem_shift;
    logic                            rem_ge;
    logic [SIZE_W:0]                 rem_diff;
    logic                            out_load;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= obsp_pkg::MODE_PARTIAL;
            side_reg       <= 1'b0;
            order_qty_reg  <= '0;
            depth_frac_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (obsp_pkg::reg_idx_t'(cfg_idx))
                obsp_pkg::REG_MODE:
                    mode_reg <= obsp_pkg::mode_t'(cfg_data[obsp_pkg::MODE_W-1:0]);
                obsp_pkg::REG_SIDE:       side_reg       <= cfg_data[0];
                obsp_pkg::REG_ORDER_QTY:  order_qty_reg  <= cfg_data[SIZE_W-1:0];
                obsp_pkg::REG_DEPTH_FRAC: depth_frac_reg <= cfg_data[FRAC_W-1:0];
            endcase
        end
    end

    assign book.ready   = (state_reg == S_IDLE);
    assign accept       = book.valid && book.ready;
    assign level_active = (level_index_reg < LVL_W'(MAX_LEVELS));
    assign in_px        = side_reg ? book.data.ask_price : book.data.bid_price;
    assign in_sz        = side_reg ? book.data.ask_size  : book.data.bid_size;

    assign take         = (sz_reg < remaining_reg) ? sz_reg : remaining_reg;
    assign sweep_go     = !walk_stopped_reg && (remaining_reg != '0);
    assign depth_factor = side_reg ? ((FRAC_W+1)'(1) << FRAC_W) + {1'b0, depth_frac_reg}
                                   : ((FRAC_W+1)'(1) << FRAC_W) - {1'b0, depth_frac_reg};
    assign fill_price   = (last_touched_reg != '0) ? last_touched_reg : best_price_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SWEEP_MUL:
            begin
                mul_a = MUL_W'(take);
                mul_b = MUL_W'(px_reg);
            end
            S_SWEEP_ACC:
            begin
                mul_a = MUL_W'(mid_twice_reg);
                mul_b = MUL_W'(depth_factor);
            end
            S_FINAL:
            begin
                mul_a = MUL_W'(remaining_reg);
                mul_b = MUL_W'(fill_price);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign depth_lhs    = PROD_W'(px_reg) << (FRAC_W + 1);
    assign depth_beyond = side_reg ? (depth_lhs > product_reg) : (depth_lhs < product_reg);

    assign dividend = (mode_reg == obsp_pkg::MODE_FULL)
                    ? notional_reg + product_reg[DIV_N-1:0] : notional_reg;
    assign divisor  = (mode_reg == obsp_pkg::MODE_FULL)
                    ? filled_reg + remaining_reg : filled_reg;

    assign rem_shift = {div_rem_reg, quo_reg[DIV_N-1]};
    assign rem_ge    = (rem_shift >= {1'b0, divisor_reg});
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};

    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            px_reg            <= '0;
            sz_reg            <= '0;
            last_reg          <= 1'b0;
            level_index_reg   <= '0;
            remaining_reg     <= '0;
            notional_reg      <= '0;
            filled_reg        <= '0;
            last_touched_reg  <= '0;
            best_price_reg    <= '0;
            mid_twice_reg     <= '0;
            depth_sum_reg     <= '0;
            walk_stopped_reg  <= 1'b0;
            depth_stopped_reg <= 1'b0;
            product_reg       <= '0;
            quo_reg           <= '0;
            div_rem_reg       <= '0;
            divisor_reg       <= '0;
            div_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
            out_data_reg      <= '0;
        end
        else
        begin
            product_reg <= mul_a * mul_b;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        px_reg   <= in_px;
                        sz_reg   <= in_sz;
                        last_reg <= book.data.last_level;
                        if (level_index_reg == '0)
                        begin
                            remaining_reg     <= order_qty_reg;
                            notional_reg      <= '0;
                            filled_reg        <= '0;
                            last_touched_reg  <= '0;
                            best_price_reg    <= in_px;
                            mid_twice_reg     <= MID_W'(book.data.bid_price)
                                               + MID_W'(book.data.ask_price);
                            depth_sum_reg     <= '0;
                            walk_stopped_reg  <= 1'b0;
                            depth_stopped_reg <= 1'b0;
                        end
                        if (level_active)
                        begin
                            state_reg <= S_SWEEP_MUL;
                        end
                        else if (book.data.last_level)
                        begin
                            state_reg <= S_FINAL;
                        end
                    end
                end
                S_SWEEP_MUL:
                begin
                    state_reg <= S_SWEEP_ACC;
                end
                S_SWEEP_ACC:
                begin
                    if (sweep_go)
                    begin
                        if (px_reg == '0)
                        begin
                            walk_stopped_reg <= 1'b1;
                        end
                        else
                        begin
                            notional_reg     <= notional_reg + product_reg[DIV_N-1:0];
                            filled_reg       <= filled_reg + take;
                            remaining_reg    <= remaining_reg - take;
                            last_touched_reg <= px_reg;
                        end
                    end
                    state_reg <= S_DEPTH;
                end
                S_DEPTH:
                begin
                    if (!depth_stopped_reg)
                    begin
                        if ((px_reg == '0) || depth_beyond)
                        begin
                            depth_stopped_reg <= 1'b1;
                        end
                        else
                        begin
                            depth_sum_reg <= depth_sum_reg + DEPTH_W'(sz_reg);
                        end
                    end
                    level_index_reg <= level_index_reg + LVL_W'(1);
                    state_reg       <= last_reg ? S_FINAL : S_IDLE;
                end
                S_FINAL:
                begin
                    if (mode_reg == obsp_pkg::MODE_DEPTH)
                    begin
                        quo_reg   <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    quo_reg     <= (divisor == '0) ? '0 : dividend;
                    div_rem_reg <= '0;
                    divisor_reg <= divisor;
                    div_cnt_reg <= CNT_W'(DIV_N - 1);
                    state_reg   <= (divisor == '0) ? S_OUT : S_DIV;
                end
                S_DIV:
                begin
                    div_rem_reg <= rem_ge ? rem_diff[SIZE_W-1:0] : rem_shift[SIZE_W-1:0];
                    quo_reg     <= {quo_reg[DIV_N-2:0], rem_ge};
                    div_cnt_reg <= div_cnt_reg - CNT_W'(1);
                    if (div_cnt_reg == '0)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        out_data_reg.avg_price   <= quo_reg[PRICE_W-1:0];
                        out_data_reg.filled_qty  <= filled_reg;
                        out_data_reg.depth_total <= (mode_reg == obsp_pkg::MODE_DEPTH)
                                                  ? depth_sum_reg : '0;
                        level_index_reg          <= '0;
                        state_reg                <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule
